// ----- hw/rtl/quadrature_encoder_bounded_value_macros.svh -----
// Assertion macros shared by the quadrature encoder value block.
`ifndef QUADRATURE_ENCODER_BOUNDED_VALUE_MACROS_SVH
`define QUADRATURE_ENCODER_BOUNDED_VALUE_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define QEBV_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("qebv same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define QEBV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("qebv next-cycle check failed");

`endif

// ----- hw/rtl/qebv_pkg.sv -----
// Shared constants and types for the quadrature encoder value block.
package qebv_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int STEP_WIDTH  = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = VALUE_WIDTH;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;
    typedef logic [STEP_WIDTH-1:0]         t_step;
    typedef logic signed [1:0]             t_detent;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOWER_LIMIT = 2'd0,
        CFG_UPPER_LIMIT = 2'd1,
        CFG_STEP_SIZE   = 2'd2,
        CFG_INPUT_LOCK  = 2'd3
    } t_cfg_idx;

    // Detent codes as they appear on the result channel.
    localparam t_detent DETENT_NONE = 2'sb00;
    localparam t_detent DETENT_UP   = 2'sb01;
    localparam t_detent DETENT_DOWN = 2'sb11;

    // Reset values of the registers.
    localparam t_value RST_LOWER_LIMIT = t_value'(0);
    localparam t_value RST_UPPER_LIMIT = t_value'(100);
    localparam t_step  RST_STEP_SIZE   = t_step'(1);

    // Detent report from the decoder to the value stage.
    typedef struct packed {
        logic up;
        logic down;
    } t_step_ctl;

endpackage

// ----- hw/rtl/qebv_in_if.sv -----
// Input channel: one pin sample and the value to adjust per beat.
interface qebv_in_if;
    import qebv_pkg::*;

    logic   valid;
    logic   ready;
    logic   pin_a;
    logic   pin_b;
    t_value present_value;

    modport source (output valid, output pin_a, output pin_b, output present_value,
                    input ready);
    modport sink   (input valid, input pin_a, input pin_b, input present_value,
                    output ready);
endinterface

// ----- hw/rtl/qebv_out_if.sv -----
// Result channel: adjusted value and detent per beat.
interface qebv_out_if;
    import qebv_pkg::*;

    logic    valid;
    logic    ready;
    t_value  adjusted_value;
    t_detent detent;

    modport source (output valid, output adjusted_value, output detent, input ready);
    modport sink   (input valid, input adjusted_value, input detent, output ready);
endinterface

// ----- hw/rtl/qebv_decoder.sv -----
// Quadrature phase decoder with sub-step accumulator and detent report.
module qebv_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  logic                i_lock,
    input  logic                i_pin_a,
    input  logic                i_pin_b,
    output qebv_pkg::t_step_ctl o_step
);
    import qebv_pkg::*;

    logic [1:0] r_prev_phase;
    logic [1:0] n_prev_phase;
    logic [1:0] r_substep;
    logic [1:0] n_substep;
    logic [1:0] w_phase;
    logic [1:0] w_diff;

    // Gray-decode the pins and compare with the last phase.
    assign w_phase = {i_pin_a, i_pin_a ^ i_pin_b};
    assign w_diff  = r_prev_phase - w_phase;

    always_comb begin
        n_prev_phase = r_prev_phase;
        n_substep    = r_substep;
        o_step       = '0;
        if (!i_lock && w_diff[0]) begin
            n_prev_phase = w_phase;
            if (w_diff[1]) begin
                o_step.up = (r_substep == 2'd3);
                n_substep = r_substep + 2'd1;
            end else begin
                o_step.down = (r_substep == 2'd0);
                n_substep   = r_substep - 2'd1;
            end
        end
    end

    // Advance state only when the sample moves on to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_phase <= '0;
            r_substep    <= '0;
        end else if (i_advance) begin
            r_prev_phase <= n_prev_phase;
            r_substep    <= n_substep;
        end
    end
endmodule

// ----- hw/rtl/quadrature_encoder_bounded_value.sv -----
// Quadrature encoder decoder that steps a value by detents and clamps it to
// configurable limits. Each input beat (pin levels plus present value) gives
// exactly one result beat. The block takes one beat per cycle while the
// result side keeps taking beats: a beat is held in the input register,
// where phase decode, sub-step update and the wide add-and-clamp run, and
// then lands in the result register. While input_lock is set the value
// passes through with detent 0 and the decoder state holds. Write registers
// only while idle.
module quadrature_encoder_bounded_value (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [qebv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [qebv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    qebv_in_if.sink                      i_in,
    qebv_out_if.source                   o_out
);
    import qebv_pkg::*;
    `include "quadrature_encoder_bounded_value_macros.svh"

    localparam int WIDE_W = VALUE_WIDTH + 2;
    typedef logic signed [WIDE_W-1:0] t_wide;

    t_value r_lower;
    t_value r_upper;
    t_step  r_step;
    logic   r_lock;

    logic   r_s1_valid;
    logic   r_s1_pin_a;
    logic   r_s1_pin_b;
    t_value r_s1_value;

    logic    r_out_valid;
    t_value  r_out_value;
    t_detent r_out_detent;

    logic      w_s1_advance;
    t_step_ctl w_step;
    t_wide     w_val;
    t_wide     w_lower;
    t_wide     w_upper;
    t_wide     n_val;
    t_detent   n_detent;

    // Write configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= RST_LOWER_LIMIT;
            r_upper <= RST_UPPER_LIMIT;
            r_step  <= RST_STEP_SIZE;
            r_lock  <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LOWER_LIMIT: r_lower <= t_value'(i_cfg_data[VALUE_WIDTH-1:0]);
                CFG_UPPER_LIMIT: r_upper <= t_value'(i_cfg_data[VALUE_WIDTH-1:0]);
                CFG_STEP_SIZE:   r_step  <= i_cfg_data[STEP_WIDTH-1:0];
                CFG_INPUT_LOCK:  r_lock  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Move a beat on when the result register is free or being drained.
    assign w_s1_advance = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready   = !r_s1_valid || w_s1_advance;

    // Capture the input beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_pin_a <= i_in.pin_a;
            r_s1_pin_b <= i_in.pin_b;
            r_s1_value <= i_in.present_value;
        end
    end

    qebv_decoder u_decoder (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_s1_advance),
        .i_lock    (r_lock),
        .i_pin_a   (r_s1_pin_a),
        .i_pin_b   (r_s1_pin_b),
        .o_step    (w_step)
    );

    // Step and clamp in wide arithmetic so the value saturates.
    assign w_val   = t_wide'(r_s1_value);
    assign w_lower = t_wide'(r_lower);
    assign w_upper = t_wide'(r_upper);

    always_comb begin
        n_val    = w_val;
        n_detent = DETENT_NONE;
        if (w_step.down) begin
            n_detent = DETENT_DOWN;
            if (w_val > w_lower) begin
                n_val = w_val - t_wide'({1'b0, r_step});
            end
            if (n_val < w_lower) begin
                n_val = w_lower;
            end
        end else if (w_step.up) begin
            n_detent = DETENT_UP;
            if (w_val < w_upper) begin
                n_val = w_val + t_wide'({1'b0, r_step});
            end
            if (n_val > w_upper) begin
                n_val = w_upper;
            end
        end
    end

    // Hold the result until the sink takes the beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || o_out.ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_advance) begin
            r_out_value  <= n_val[VALUE_WIDTH-1:0];
            r_out_detent <= n_detent;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.adjusted_value = r_out_value;
    assign o_out.detent         = r_out_detent;

    // Lock blocks any detent, a stalled beat stays put, and a busy input
    // register is the only reason to refuse a beat.
    `QEBV_ASSERT_SAME(a_lock_no_detent, i_clk, i_rst_n, r_lock, w_step == '0)
    `QEBV_ASSERT_SAME(a_one_direction, i_clk, i_rst_n, 1'b1, !(w_step.up && w_step.down))
    `QEBV_ASSERT_NEXT(a_s1_holds, i_clk, i_rst_n, r_s1_valid && !w_s1_advance, r_s1_valid)
    `QEBV_ASSERT_SAME(a_ready_busy, i_clk, i_rst_n, !i_in.ready, r_s1_valid && r_out_valid)
endmodule

// ----- bench/qebv_checker.sv -----
// Checker for the quadrature encoder value block: predicts each result beat and compares.
module qebv_checker
    import qebv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    qebv_in_if                    i_in,
    qebv_out_if                   i_out,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        t_value  value;
        t_detent detent;
    } t_sample_result;

    // Shadow copy of the registers and of the decoder state
    t_value     lower_limit;
    t_value     upper_limit;
    t_step      step_size;
    logic       input_lock;
    logic [1:0] last_phase;
    logic [1:0] substeps;

    t_sample_result awaited_results[$];
    int             fail_total = 0;
    int             awaited_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = awaited_total;

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        fail_total++;
    endtask

    // Decode one pin sample, advance the sub-step count and step the value.
    function automatic t_sample_result advance_encoder(input logic pin_a, input logic pin_b,
                                                       input t_value present);
        logic [1:0] phase;
        logic [1:0] delta;
        t_detent    detent;
        int         acc;
        detent = DETENT_NONE;
        acc    = int'(present);
        if (!input_lock) begin
            phase = {pin_a, pin_a ^ pin_b};
            delta = last_phase - phase;
            // odd moves count, a jump by two phases is lost
            if (delta[0]) begin
                last_phase = phase;
                if (delta[1]) begin
                    if (substeps == 2'd3) detent = DETENT_UP;
                    substeps = substeps + 2'd1;
                end else begin
                    if (substeps == 2'd0) detent = DETENT_DOWN;
                    substeps = substeps - 2'd1;
                end
            end
        end
        // Step and clamp in wide arithmetic
        if (detent == DETENT_DOWN) begin
            if (acc > int'(lower_limit)) acc -= int'(step_size);
            if (acc < int'(lower_limit)) acc = int'(lower_limit);
        end else if (detent == DETENT_UP) begin
            if (acc < int'(upper_limit)) acc += int'(step_size);
            if (acc > int'(upper_limit)) acc = int'(upper_limit);
        end
        return '{value: t_value'(acc), detent: detent};
    endfunction

    always @(posedge i_clk) begin
        t_sample_result seen;
        if (!i_rst_n) begin
            lower_limit = RST_LOWER_LIMIT;
            upper_limit = RST_UPPER_LIMIT;
            step_size   = RST_STEP_SIZE;
            input_lock  = 1'b0;
            last_phase  = 2'd0;
            substeps    = 2'd0;
            awaited_results.delete();
        end else begin
            // Predict on every accepted input beat
            if (i_in.valid && i_in.ready) begin
                awaited_results.push_back(
                    advance_encoder(i_in.pin_a, i_in.pin_b, i_in.present_value));
            end
            // Compare every accepted result beat with the oldest prediction
            if (i_out.valid && i_out.ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result beat with no sample waiting");
                end else begin
                    seen = awaited_results.pop_front();
                    if (i_out.adjusted_value !== seen.value)
                        report_mismatch($sformatf("adjusted_value %0d, predicted %0d",
                                                  i_out.adjusted_value, seen.value));
                    if (i_out.detent !== seen.detent)
                        report_mismatch($sformatf("detent %0d, predicted %0d",
                                                  i_out.detent, seen.detent));
                end
            end
            // Track register writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_LOWER_LIMIT: lower_limit = t_value'(i_cfg_data);
                    CFG_UPPER_LIMIT: upper_limit = t_value'(i_cfg_data);
                    CFG_STEP_SIZE:   step_size   = i_cfg_data[STEP_WIDTH-1:0];
                    CFG_INPUT_LOCK:  input_lock  = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        awaited_total = awaited_results.size();
    end

endmodule

// ----- bench/tb.sv -----
// Top of the regression: drives encoder samples and settings, then gives the verdict.
module tb;
    import qebv_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_PHASES   = 11;
    localparam int BEATS_PER_PHASE = 150;

    typedef struct packed {
        t_value lower;
        t_value upper;
        t_step  step;
        logic   lock;
    } t_settings;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int         fail_count;
    int         pending;
    int         cycle_count;
    int         gap_pct;
    int         stall_pct;
    int         run_left;
    int         run_dir;
    logic [1:0] pin_phase;
    t_settings  active;

    qebv_in_if  in_ch ();
    qebv_out_if out_ch ();

    quadrature_encoder_bounded_value dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    qebv_checker detent_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stop a hung run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: drop ready in short random bursts
    initial begin
        int hold;
        hold = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold == 0 && $urandom_range(0, 99) < stall_pct) hold = $urandom_range(1, 3);
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                hold--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Send one sample beat and hold it until the block takes it.
    task automatic send_beat(input logic [1:0] phase, input t_value value);
        if ($urandom_range(0, 99) < gap_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.pin_a         <= phase[1];
        in_ch.pin_b         <= phase[1] ^ phase[0];
        in_ch.present_value <= value;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Turn the knob by delta phases and sample it.
    task automatic move(input int delta, input t_value value);
        pin_phase = pin_phase + 2'(delta);
        send_beat(pin_phase, value);
    endtask

    // Wait until every predicted result has come back.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Write all four registers; junk in the unused upper bits must be dropped.
    task automatic load_settings(input t_settings s);
        active     = s;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LOWER_LIMIT;
        cfg_data  <= s.lower;
        @(posedge i_clk);
        cfg_index <= CFG_UPPER_LIMIT;
        cfg_data  <= s.upper;
        @(posedge i_clk);
        cfg_index <= CFG_STEP_SIZE;
        cfg_data  <= {8'($urandom), s.step};
        @(posedge i_clk);
        cfg_index <= CFG_INPUT_LOCK;
        cfg_data  <= {15'($urandom), s.lock};
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly steady turns in one direction, some stalls and phase jumps.
    function automatic int next_delta();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return 0;
        if (pick == 1) return 2;
        if (run_left == 0) begin
            run_dir  = $urandom_range(0, 1) ? 1 : -1;
            run_left = $urandom_range(1, 12);
        end
        run_left--;
        return run_dir;
    endfunction

    // Values cluster around the limits, with extremes and full-range noise.
    function automatic t_value pick_value();
        int span;
        int base;
        span = int'(active.step) + 4;
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? t_value'(32767) : t_value'(-32768);
            1: base = int'(active.lower);
            2: base = int'(active.upper);
            default: return t_value'($urandom);
        endcase
        base = base + int'($urandom_range(0, 2 * span)) - span;
        if (base > 32767) base = 32767;
        if (base < -32768) base = -32768;
        return t_value'(base);
    endfunction

    // Settings per random phase: extremes first, then random windows.
    function automatic t_settings phase_settings(input int phase);
        t_settings s;
        int        lo;
        int        width;
        s.lock = 1'b0;
        s.step = t_step'($urandom_range(0, 255));
        case (phase)
            0: begin
                s.lower = t_value'(-32768);
                s.upper = t_value'(32767);
                s.step  = t_step'(255);
            end
            1: begin
                s.lower = t_value'(-32768);
                s.upper = t_value'(32767);
                s.step  = t_step'(0);
            end
            2: begin
                s.lower = t_value'(-20);
                s.upper = t_value'(20);
                s.lock  = 1'b1;
            end
            3: begin
                // inverted window
                s.lower = t_value'(500);
                s.upper = t_value'(-500);
            end
            4: begin
                s.lower = t_value'(32767);
                s.upper = t_value'(32767);
                s.step  = t_step'(255);
            end
            5: begin
                s.lower = t_value'(-32768);
                s.upper = t_value'(-32768);
            end
            default: begin
                width = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 600);
                lo = int'($urandom_range(0, 65535)) - 32768;
                if (lo + width > 32767) lo = 32767 - width;
                s.lower = t_value'(lo);
                s.upper = t_value'(lo + width);
                s.step  = ($urandom_range(0, 3) == 0) ? t_step'($urandom_range(0, 255))
                                                      : t_step'($urandom_range(1, 9));
            end
        endcase
        return s;
    endfunction

    initial begin
        t_value probe [4];
        probe = '{t_value'(-32768), t_value'(32767), t_value'(0), t_value'(40)};

        i_rst_n             <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= CFG_LOWER_LIMIT;
        cfg_data            <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.pin_a         <= 1'b0;
        in_ch.pin_b         <= 1'b0;
        in_ch.present_value <= '0;
        gap_pct   = 25;
        stall_pct = 25;
        run_left  = 0;
        run_dir   = 1;
        pin_phase = 2'd0;
        active    = '{lower: RST_LOWER_LIMIT, upper: RST_UPPER_LIMIT,
                      step: RST_STEP_SIZE, lock: 1'b0};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: one full detent up, then clamps and pass-through
        repeat (3) move(1, 50);
        move(1, 32767);
        move(1, -32768);
        move(0, 7);
        move(2, 7);
        move(2, 7);
        move(-1, 20);
        move(-1, -32768);
        repeat (3) move(-1, 0);
        move(-1, 32767);

        // Lower limit above upper limit, widest step
        settle();
        load_settings('{lower: 40, upper: -40, step: 255, lock: 1'b0});
        for (int k = 0; k < 8; k++) move((k < 4) ? 1 : -1, probe[k % 4]);

        // Lock: value passes through, decoder holds
        settle();
        load_settings('{lower: -20, upper: 20, step: 5, lock: 1'b1});
        move(1, -32768);
        move(1, 32767);
        move(-1, 1234);

        // Random phases, the last ones without idling
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            load_settings(phase_settings(p));
            if (p >= RANDOM_PHASES - 2) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
                stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
            end
            for (int n = 0; n < BEATS_PER_PHASE; n++) move(next_delta(), pick_value());
        end
        settle();

        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/qebv_pkg.sv
hw/rtl/qebv_in_if.sv
hw/rtl/qebv_out_if.sv
hw/rtl/qebv_decoder.sv
hw/rtl/quadrature_encoder_bounded_value.sv
bench/qebv_checker.sv
bench/tb.sv
